// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the parser modules; clocked on clk, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/jsep_pkg.sv =====
// Shared constants, codes, command and status types and character classes of the parser.
package jsep_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int LVL_W     = $clog2(MAX_DEPTH + 1);
    localparam int PTR_W     = $clog2(MAX_DEPTH);
    localparam int IDX_W     = 16;
    localparam logic [IDX_W-1:0] IDX_MAX = '1;

    // Frame kinds
    localparam logic [3:0] FK_VALUE     = 4'd0;
    localparam logic [3:0] FK_OBJ_KEY   = 4'd1;
    localparam logic [3:0] FK_OBJ_COLON = 4'd2;
    localparam logic [3:0] FK_OBJ_VAL   = 4'd3;
    localparam logic [3:0] FK_OBJ_SEP   = 4'd4;
    localparam logic [3:0] FK_ARR_FIRST = 4'd5;
    localparam logic [3:0] FK_ARR_VAL   = 4'd6;
    localparam logic [3:0] FK_ARR_SEP   = 4'd7;
    localparam logic [3:0] FK_KEY_START = 4'd8;
    localparam logic [3:0] FK_KEY_BODY  = 4'd9;
    localparam logic [3:0] FK_KEY_ESC   = 4'd10;
    localparam logic [3:0] FK_STR_START = 4'd11;
    localparam logic [3:0] FK_STR_BODY  = 4'd12;
    localparam logic [3:0] FK_STR_ESC   = 4'd13;
    localparam logic [3:0] FK_RAW       = 4'd14;

    // Event kinds
    localparam logic [3:0] EV_NONE      = 4'd0;
    localparam logic [3:0] EV_OBJ_START = 4'd1;
    localparam logic [3:0] EV_OBJ_END   = 4'd2;
    localparam logic [3:0] EV_ARR_START = 4'd3;
    localparam logic [3:0] EV_ARR_END   = 4'd4;
    localparam logic [3:0] EV_KEY_CHAR  = 4'd5;
    localparam logic [3:0] EV_KEY_END   = 4'd6;
    localparam logic [3:0] EV_STR_CHAR  = 4'd7;
    localparam logic [3:0] EV_STR_END   = 4'd8;
    localparam logic [3:0] EV_RAW_CHAR  = 4'd9;
    localparam logic [3:0] EV_RAW_END   = 4'd10;
    localparam logic [3:0] EV_DONE      = 4'd11;
    localparam logic [3:0] EV_ERROR     = 4'd12;

    // Error codes
    localparam logic [3:0] ER_NONE      = 4'd0;
    localparam logic [3:0] ER_INTERNAL  = 4'd1;
    localparam logic [3:0] ER_STR_START = 4'd2;
    localparam logic [3:0] ER_ARR_VEND  = 4'd3;
    localparam logic [3:0] ER_ARR_VALUE = 4'd4;
    localparam logic [3:0] ER_ARR_SEP   = 4'd5;
    localparam logic [3:0] ER_COLON     = 4'd6;
    localparam logic [3:0] ER_OBJ_VALUE = 4'd7;
    localparam logic [3:0] ER_KEY_END   = 4'd8;
    localparam logic [3:0] ER_OBJ_SEP   = 4'd9;
    localparam logic [3:0] ER_INVALID   = 4'd10;
    localparam logic [3:0] ER_TOO_DEEP  = 4'd11;

    // Characters
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;

    typedef struct packed {
        logic latch;
        logic clr;
        logic pass;
        logic ld_err;
        logic ld_done;
        logic stage;
        logic flush;
    } jsep_cmd_t;

    typedef struct packed {
        logic in_nz;
        logic sticky_nz;
        logic skip;
        logic level_zero;
        logic consumed;
        logic stage_ok;
        logic hold_v;
        logic out_free;
    } jsep_sts_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
    endfunction

    function automatic logic is_raw(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h2B) || (c == 8'h2D) ||
               (c == 8'h2E);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_DQUOTE) || (c == CH_SQUOTE);
    endfunction

endpackage

// ===== hw/rtl/jsep_ctrl.sv =====
// Sequencer of the parser: frame passes, event staging and item handshake.
`include "assert_macros.svh"

module jsep_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                char_valid,
    output logic                char_stall,
    input  jsep_pkg::jsep_sts_t sts,
    output jsep_pkg::jsep_cmd_t cmd
);
    import jsep_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_START = 3'd1;
    localparam logic [2:0] S_PASS  = 3'd2;
    localparam logic [2:0] S_STAGE = 3'd3;
    localparam logic [2:0] S_ERRS  = 3'd4;
    localparam logic [2:0] S_DONES = 3'd5;
    localparam logic [2:0] S_FINAL = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       term_reg, term_next;

    // Hold state and terminal flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            term_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            term_reg  <= term_next;
        end
    end

    assign char_stall = (state_reg != S_IDLE);

    // Advance through the passes of one item
    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        term_next  = term_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (char_valid)
                begin
                    cmd.latch = 1'b1;
                    term_next = 1'b0;
                    if (sts.in_nz)
                        state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.clr = sts.level_zero;
                if (sts.sticky_nz)
                    state_next = S_ERRS;
                else if (sts.skip)
                    state_next = S_IDLE;
                else
                    state_next = S_PASS;
            end
            S_PASS:
            begin
                cmd.pass   = 1'b1;
                state_next = S_STAGE;
            end
            S_STAGE:
            begin
                if (sts.stage_ok)
                begin
                    cmd.stage = 1'b1;
                    if (term_reg)
                        state_next = S_FINAL;
                    else if (sts.sticky_nz)
                        state_next = S_ERRS;
                    else if (sts.level_zero)
                        state_next = S_DONES;
                    else if (!sts.consumed)
                        state_next = S_PASS;
                    else
                        state_next = S_FINAL;
                end
            end
            S_ERRS:
            begin
                cmd.ld_err = 1'b1;
                term_next  = 1'b1;
                state_next = S_STAGE;
            end
            S_DONES:
            begin
                cmd.ld_done = 1'b1;
                term_next   = 1'b1;
                state_next  = S_STAGE;
            end
            S_FINAL:
            begin
                if (!sts.hold_v)
                    state_next = S_IDLE;
                else if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    `ASSERT_SAME(a_pass_clean, state_reg == S_PASS, !sts.sticky_nz, "pass run with error set")
    `ASSERT_NEXT(a_term_final, cmd.stage && term_reg, state_reg == S_FINAL, "terminal event not last")
endmodule

// ===== hw/rtl/jsep_dp.sv =====
// Datapath of the parser: frame stack, frame pass logic, event hold and output registers.
`include "assert_macros.svh"

module jsep_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  jsep_pkg::jsep_cmd_t           cmd,
    output jsep_pkg::jsep_sts_t           sts,
    input  logic [7:0]                    char_in,
    input  logic                          event_stall,
    output logic                          event_valid,
    output logic [3:0]                    event_kind,
    output logic [7:0]                    data_byte,
    output logic [3:0]                    error_code,
    output logic [jsep_pkg::LVL_W-1:0]    nesting_depth,
    output logic [jsep_pkg::IDX_W-1:0]    element_index,
    output logic                          last
);
    import jsep_pkg::*;

    logic [7:0]       c_reg;
    logic [3:0]       kind_reg [MAX_DEPTH];
    logic [IDX_W-1:0] cnt_reg  [MAX_DEPTH];
    logic [LVL_W-1:0] level_reg, level_next;
    logic [3:0]       sticky_reg, sticky_next;
    logic             cons_reg;

    logic             pe_v_reg;
    logic [3:0]       pe_kind_reg, pe_code_reg;
    logic [7:0]       pe_data_reg;

    logic             hold_v_reg;
    logic [3:0]       hold_kind_reg, hold_code_reg;
    logic [7:0]       hold_data_reg;
    logic [LVL_W-1:0] hold_depth_reg;
    logic [IDX_W-1:0] hold_idx_reg;

    logic             out_v_reg;
    logic [3:0]       out_kind_reg, out_code_reg;
    logic [7:0]       out_data_reg;
    logic [LVL_W-1:0] out_depth_reg;
    logic [IDX_W-1:0] out_idx_reg;
    logic             out_last_reg;

    logic [LVL_W-1:0] lvl_m1;
    logic [PTR_W-1:0] top_ptr, push_ptr;
    logic [3:0]       k;
    logic [IDX_W-1:0] cnt_t, cur_idx;
    logic             full, level_zero, out_free, is_key, clr_any, to_out;
    logic [7:0]       esc_c;

    logic             vr_ok, vr_ev, vr_zero;
    logic [3:0]       vr_kind, vr_evk;

    logic             p_wr_top, p_push, p_pop, p_inc, p_set0, p_ev, p_cons;
    logic [3:0]       p_top_kind, p_push_kind, p_evk, p_err;
    logic [7:0]       p_evd;
    logic [IDX_W-1:0] p_push_cnt;

    // Read the top frame
    assign lvl_m1     = level_reg - LVL_W'(1);
    assign top_ptr    = lvl_m1[PTR_W-1:0];
    assign push_ptr   = level_reg[PTR_W-1:0];
    assign k          = kind_reg[top_ptr];
    assign cnt_t      = cnt_reg[top_ptr];
    assign level_zero = (level_reg == '0);
    assign full       = (level_reg >= LVL_W'(MAX_DEPTH));
    assign cur_idx    = level_zero ? '0 : cnt_t;
    assign out_free   = !out_v_reg || !event_stall;
    assign is_key     = (k <= FK_KEY_ESC);
    assign esc_c      = (c_reg == CH_N) ? 8'd10 :
                        (c_reg == CH_R) ? 8'd13 :
                        (c_reg == CH_T) ? 8'd9  : c_reg;

    // Status to the sequencer
    assign sts.in_nz      = (char_in != 8'd0);
    assign sts.sticky_nz  = (sticky_reg != ER_NONE);
    assign sts.skip       = is_space(c_reg) && (k != FK_KEY_BODY) && (k != FK_STR_BODY);
    assign sts.level_zero = level_zero;
    assign sts.consumed   = cons_reg;
    assign sts.stage_ok   = !pe_v_reg || !hold_v_reg || out_free;
    assign sts.hold_v     = hold_v_reg;
    assign sts.out_free   = out_free;

    // Classify a byte that opens a value
    always_comb
    begin
        vr_ok   = 1'b1;
        vr_kind = FK_VALUE;
        vr_ev   = 1'b0;
        vr_evk  = EV_NONE;
        vr_zero = 1'b0;
        if (c_reg == CH_LBRACE)
        begin
            vr_kind = FK_OBJ_KEY;
            vr_ev   = 1'b1;
            vr_evk  = EV_OBJ_START;
        end
        else if (c_reg == CH_LBRACK)
        begin
            vr_kind = FK_ARR_FIRST;
            vr_ev   = 1'b1;
            vr_evk  = EV_ARR_START;
            vr_zero = 1'b1;
        end
        else if (c_reg == CH_U)
            vr_kind = FK_STR_START;
        else if (is_quote(c_reg))
            vr_kind = FK_STR_BODY;
        else if (is_raw(c_reg))
        begin
            vr_kind = FK_RAW;
            vr_ev   = 1'b1;
            vr_evk  = EV_RAW_CHAR;
        end
        else
            vr_ok = 1'b0;
    end

    // One pass over the top frame
    always_comb
    begin
        p_wr_top    = 1'b0;
        p_top_kind  = k;
        p_push      = 1'b0;
        p_push_kind = FK_VALUE;
        p_push_cnt  = cnt_t;
        p_pop       = 1'b0;
        p_inc       = 1'b0;
        p_set0      = 1'b0;
        p_ev        = 1'b0;
        p_evk       = EV_NONE;
        p_evd       = 8'd0;
        p_err       = ER_NONE;
        p_cons      = 1'b0;
        case (k)
            FK_VALUE:
            begin
                if (vr_ok)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = vr_kind;
                    p_set0     = vr_zero;
                    p_ev       = vr_ev;
                    p_evk      = vr_evk;
                    p_evd      = (vr_evk == EV_RAW_CHAR) ? c_reg : 8'd0;
                    p_cons     = 1'b1;
                end
                else
                begin
                    p_pop = 1'b1;
                    p_err = ER_INVALID;
                end
            end
            FK_OBJ_KEY, FK_OBJ_SEP:
            begin
                if (c_reg == CH_RBRACE)
                begin
                    p_pop  = 1'b1;
                    p_ev   = 1'b1;
                    p_evk  = EV_OBJ_END;
                    p_cons = 1'b1;
                end
                else if (k == FK_OBJ_KEY)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = FK_OBJ_COLON;
                    if (full)
                        p_err = ER_TOO_DEEP;
                    else
                    begin
                        p_push      = 1'b1;
                        p_push_kind = is_quote(c_reg) ? FK_KEY_BODY : FK_KEY_START;
                        if ((c_reg == CH_U) || is_quote(c_reg))
                            p_cons = 1'b1;
                        else
                            p_err = ER_KEY_END;
                    end
                end
                else if (c_reg == CH_COMMA)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = FK_OBJ_COLON;
                    if (full)
                        p_err = ER_TOO_DEEP;
                    else
                    begin
                        p_push      = 1'b1;
                        p_push_kind = FK_KEY_START;
                        p_cons      = 1'b1;
                    end
                end
                else
                    p_err = ER_OBJ_SEP;
            end
            FK_OBJ_COLON:
            begin
                if (c_reg == CH_COLON)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = FK_OBJ_VAL;
                    p_cons     = 1'b1;
                end
                else
                    p_err = ER_COLON;
            end
            FK_OBJ_VAL, FK_ARR_FIRST, FK_ARR_VAL:
            begin
                if ((k == FK_ARR_FIRST) && (c_reg == CH_RBRACK))
                begin
                    p_pop  = 1'b1;
                    p_ev   = 1'b1;
                    p_evk  = EV_ARR_END;
                    p_cons = 1'b1;
                end
                else
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = (k == FK_OBJ_VAL) ? FK_OBJ_SEP : FK_ARR_SEP;
                    if (full)
                        p_err = ER_TOO_DEEP;
                    else if (vr_ok)
                    begin
                        p_push      = 1'b1;
                        p_push_kind = vr_kind;
                        p_push_cnt  = vr_zero ? '0 : cnt_t;
                        p_ev        = vr_ev;
                        p_evk       = vr_evk;
                        p_evd       = (vr_evk == EV_RAW_CHAR) ? c_reg : 8'd0;
                        p_cons      = 1'b1;
                    end
                    else if (k == FK_OBJ_VAL)
                        p_err = ER_OBJ_VALUE;
                    else if (k == FK_ARR_FIRST)
                        p_err = ER_ARR_VEND;
                    else
                        p_err = ER_ARR_VALUE;
                end
            end
            FK_ARR_SEP:
            begin
                if (c_reg == CH_RBRACK)
                begin
                    p_pop  = 1'b1;
                    p_ev   = 1'b1;
                    p_evk  = EV_ARR_END;
                    p_cons = 1'b1;
                end
                else if (c_reg == CH_COMMA)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = FK_ARR_VAL;
                    p_inc      = (cnt_t != IDX_MAX);
                    p_cons     = 1'b1;
                end
                else
                    p_err = ER_ARR_SEP;
            end
            FK_KEY_START, FK_STR_START:
            begin
                if (c_reg == CH_U)
                    p_cons = 1'b1;
                else if (is_quote(c_reg))
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = k + 4'd1;
                    p_cons     = 1'b1;
                end
                else
                    p_err = ER_STR_START;
            end
            FK_KEY_BODY, FK_STR_BODY:
            begin
                p_cons = 1'b1;
                if (is_quote(c_reg))
                begin
                    p_pop = 1'b1;
                    p_ev  = 1'b1;
                    p_evk = is_key ? EV_KEY_END : EV_STR_END;
                end
                else if (c_reg == CH_BSLASH)
                begin
                    p_wr_top   = 1'b1;
                    p_top_kind = k + 4'd1;
                end
                else
                begin
                    p_ev  = 1'b1;
                    p_evk = is_key ? EV_KEY_CHAR : EV_STR_CHAR;
                    p_evd = c_reg;
                end
            end
            FK_KEY_ESC, FK_STR_ESC:
            begin
                p_wr_top   = 1'b1;
                p_top_kind = k - 4'd1;
                p_ev       = 1'b1;
                p_evk      = is_key ? EV_KEY_CHAR : EV_STR_CHAR;
                p_evd      = esc_c;
                p_cons     = 1'b1;
            end
            FK_RAW:
            begin
                p_ev = 1'b1;
                if (is_raw(c_reg))
                begin
                    p_evk  = EV_RAW_CHAR;
                    p_evd  = c_reg;
                    p_cons = 1'b1;
                end
                else
                begin
                    p_pop = 1'b1;
                    p_evk = EV_RAW_END;
                end
            end
            default:
            begin
                p_err = ER_INTERNAL;
            end
        endcase
    end

    assign clr_any = cmd.clr || (cmd.stage && pe_v_reg && (pe_kind_reg == EV_DONE));
    assign to_out  = (cmd.stage && pe_v_reg && hold_v_reg) || cmd.flush;

    // Next level and error code
    always_comb
    begin
        level_next  = level_reg;
        sticky_next = sticky_reg;
        if (clr_any)
            level_next = LVL_W'(1);
        else if (cmd.pass)
        begin
            if (p_push)
                level_next = level_reg + LVL_W'(1);
            else if (p_pop)
                level_next = lvl_m1;
            if (p_err != ER_NONE)
                sticky_next = p_err;
        end
    end

    // Hold the frame stack and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DEPTH; i++)
            begin
                kind_reg[i] <= FK_VALUE;
                cnt_reg[i]  <= '0;
            end
            level_reg  <= LVL_W'(1);
            sticky_reg <= ER_NONE;
            cons_reg   <= 1'b0;
            pe_v_reg   <= 1'b0;
            hold_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            level_reg  <= level_next;
            sticky_reg <= sticky_next;
            if (clr_any)
            begin
                kind_reg[0] <= FK_VALUE;
                cnt_reg[0]  <= '0;
            end
            else if (cmd.pass)
            begin
                cons_reg <= p_cons;
                if (p_wr_top)
                    kind_reg[top_ptr] <= p_top_kind;
                if (p_set0)
                    cnt_reg[top_ptr] <= '0;
                else if (p_inc)
                    cnt_reg[top_ptr] <= cnt_t + IDX_W'(1);
                if (p_push)
                begin
                    kind_reg[push_ptr] <= p_push_kind;
                    cnt_reg[push_ptr]  <= p_push_cnt;
                end
            end
            // Pending event of this pass, or error and done events
            if (cmd.pass)
                pe_v_reg <= p_ev;
            else if (cmd.ld_err || cmd.ld_done)
                pe_v_reg <= 1'b1;
            else if (cmd.stage)
                pe_v_reg <= 1'b0;
            // Hold the staged event until its successor decides last
            if (cmd.stage && pe_v_reg)
                hold_v_reg <= 1'b1;
            else if (cmd.flush)
                hold_v_reg <= 1'b0;
            if (to_out)
                out_v_reg <= 1'b1;
            else if (!event_stall)
                out_v_reg <= 1'b0;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
            c_reg <= char_in;
        if (cmd.pass)
        begin
            pe_kind_reg <= p_evk;
            pe_data_reg <= p_evd;
            pe_code_reg <= ER_NONE;
        end
        else if (cmd.ld_err)
        begin
            pe_kind_reg <= EV_ERROR;
            pe_data_reg <= 8'd0;
            pe_code_reg <= sticky_reg;
        end
        else if (cmd.ld_done)
        begin
            pe_kind_reg <= EV_DONE;
            pe_data_reg <= 8'd0;
            pe_code_reg <= ER_NONE;
        end
        if (to_out)
        begin
            out_kind_reg  <= hold_kind_reg;
            out_data_reg  <= hold_data_reg;
            out_code_reg  <= hold_code_reg;
            out_depth_reg <= hold_depth_reg;
            out_idx_reg   <= hold_idx_reg;
            out_last_reg  <= cmd.flush;
        end
        if (cmd.stage && pe_v_reg)
        begin
            hold_kind_reg  <= pe_kind_reg;
            hold_data_reg  <= pe_data_reg;
            hold_code_reg  <= pe_code_reg;
            hold_depth_reg <= level_reg;
            hold_idx_reg   <= cur_idx;
        end
    end

    assign event_valid   = out_v_reg;
    assign event_kind    = out_kind_reg;
    assign data_byte     = out_data_reg;
    assign error_code    = out_code_reg;
    assign nesting_depth = out_depth_reg;
    assign element_index = out_idx_reg;
    assign last          = out_last_reg;

    `ASSERT_SAME(a_no_overwrite, to_out, out_free, "output item overwritten while stalled")
    `ASSERT_NEXT(a_sticky_hold, sticky_reg != ER_NONE, sticky_reg == $past(sticky_reg), "error code lost")
    `ASSERT_ALWAYS(a_level_range, level_reg <= LVL_W'(MAX_DEPTH), "stack level beyond depth")
endmodule

// ===== hw/rtl/json_stream_event_parser_unit.sv =====
// Top level of the byte-serial JSON event parser: sequencer plus datapath.
// An accepted byte is latched, run by a frame pass into the pending event, staged into the hold register,
// then moved to the output register; output stalls add to this. Bytes are taken one at a time.
// Whitespace outside string and key bodies and a zero byte give no event, but whitespace with an error set gives it.
// Reset: asynchronous, active low; stack holds one value frame, error cleared, no event pending.
module json_stream_event_parser_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       char_valid,
    output logic                       char_stall,
    input  logic [7:0]                 char_in,
    output logic                       event_valid,
    input  logic                       event_stall,
    output logic [3:0]                 event_kind,
    output logic [7:0]                 data_byte,
    output logic [3:0]                 error_code,
    output logic [jsep_pkg::LVL_W-1:0] nesting_depth,
    output logic [jsep_pkg::IDX_W-1:0] element_index,
    output logic                       last
);
    import jsep_pkg::*;

    jsep_cmd_t cmd;
    jsep_sts_t sts;

    jsep_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_stall (char_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    jsep_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .char_in       (char_in),
        .event_stall   (event_stall),
        .event_valid   (event_valid),
        .event_kind    (event_kind),
        .data_byte     (data_byte),
        .error_code    (error_code),
        .nesting_depth (nesting_depth),
        .element_index (element_index),
        .last          (last)
    );
endmodule

// ===== tb/sv/json_stream_event_parser_unit_tb.sv =====
// Testbench for the byte-serial JSON event parser: predicts events per byte and checks them.
`timescale 1ns / 1ps

module json_stream_event_parser_unit_tb;
    import jsep_pkg::*;

    typedef struct packed {
        logic [3:0]       kind;
        logic [7:0]       data;
        logic [3:0]       code;
        logic [LVL_W-1:0] depth;
        logic [IDX_W-1:0] index;
        logic             last;
    } parse_event_t;

    logic             clk;
    logic             rst_n;
    logic             char_valid;
    logic             char_stall;
    logic [7:0]       char_in;
    logic             event_valid;
    logic             event_stall;
    logic [3:0]       event_kind;
    logic [7:0]       data_byte;
    logic [3:0]       error_code;
    logic [LVL_W-1:0] nesting_depth;
    logic [IDX_W-1:0] element_index;
    logic             last;

    // predictor state
    logic [3:0]       pk_kind [MAX_DEPTH];
    logic [IDX_W-1:0] pk_count [MAX_DEPTH];
    int               pk_level;
    logic [3:0]       pk_err;
    parse_event_t     step_events [$];

    logic [7:0]       pending_bytes [$];
    parse_event_t     expected_events [$];
    int               fail_count;
    int               hold_off;
    bit               hold_req;
    bit               sender_pause;
    int               burst_left;
    int               gap_left;
    int               stall_phase;

    json_stream_event_parser_unit dut (
        .clk(clk), .rst_n(rst_n),
        .char_valid(char_valid), .char_stall(char_stall), .char_in(char_in),
        .event_valid(event_valid), .event_stall(event_stall),
        .event_kind(event_kind), .data_byte(data_byte), .error_code(error_code),
        .nesting_depth(nesting_depth), .element_index(element_index), .last(last)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic bit space_char(logic [7:0] c);
        return c == 8'h20 || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic bit token_char(logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") ||
               (c >= "A" && c <= "Z") || c == "+" || c == "-" || c == ".";
    endfunction

    function automatic bit quote_char(logic [7:0] c);
        return c == CH_DQUOTE || c == CH_SQUOTE;
    endfunction

    function automatic void add_event(logic [3:0] kind, logic [7:0] data, logic [3:0] code);
        parse_event_t e;
        logic [IDX_W-1:0] idx;
        idx = '0;
        if (step_events.size() >= 3) return;
        for (int i = pk_level; i > 0; i--)
        begin
            if (pk_kind[i-1] >= FK_ARR_FIRST && pk_kind[i-1] <= FK_ARR_SEP)
            begin
                idx = pk_count[i-1];
                break;
            end
        end
        e.kind = kind; e.data = data; e.code = code;
        e.depth = pk_level[LVL_W-1:0]; e.index = idx; e.last = 1'b0;
        step_events.push_back(e);
    endfunction

    function automatic bit push_frame(logic [3:0] kind);
        if (pk_level >= MAX_DEPTH)
        begin
            pk_err = ER_TOO_DEEP;
            return 0;
        end
        pk_kind[pk_level] = kind;
        pk_count[pk_level] = '0;
        pk_level++;
        return 1;
    endfunction

    function automatic bit text_step(logic [7:0] c);
        int t;
        bit is_key;
        logic [3:0] base;
        t = pk_level - 1;
        is_key = pk_kind[t] <= FK_KEY_ESC;
        base = is_key ? FK_KEY_START : FK_STR_START;
        if (pk_kind[t] == base)
        begin
            if (c == CH_U) return 1;
            if (quote_char(c))
            begin
                pk_kind[t] = base + 4'd1;
                return 1;
            end
            pk_err = ER_STR_START;
            return 0;
        end
        if (pk_kind[t] == base + 4'd1)
        begin
            if (quote_char(c))
            begin
                pk_level--;
                add_event(is_key ? EV_KEY_END : EV_STR_END, 8'd0, ER_NONE);
                return 1;
            end
            if (c == CH_BSLASH)
            begin
                pk_kind[t] = base + 4'd2;
                return 1;
            end
            add_event(is_key ? EV_KEY_CHAR : EV_STR_CHAR, c, ER_NONE);
            return 1;
        end
        // translate escape
        if (c == CH_N) c = 8'd10;
        else if (c == CH_R) c = 8'd13;
        else if (c == CH_T) c = 8'd9;
        pk_kind[t] = base + 4'd1;
        add_event(is_key ? EV_KEY_CHAR : EV_STR_CHAR, c, ER_NONE);
        return 1;
    endfunction

    function automatic bit value_step(logic [7:0] c);
        int t;
        t = pk_level - 1;
        if (c == CH_LBRACE)
        begin
            pk_kind[t] = FK_OBJ_KEY;
            add_event(EV_OBJ_START, 8'd0, ER_NONE);
            return 1;
        end
        if (c == CH_LBRACK)
        begin
            pk_kind[t] = FK_ARR_FIRST;
            pk_count[t] = '0;
            add_event(EV_ARR_START, 8'd0, ER_NONE);
            return 1;
        end
        if (c == CH_U || quote_char(c))
        begin
            pk_kind[t] = FK_STR_START;
            return text_step(c);
        end
        if (token_char(c))
        begin
            pk_kind[t] = FK_RAW;
            add_event(EV_RAW_CHAR, c, ER_NONE);
            return 1;
        end
        pk_level--;
        return 0;
    endfunction

    function automatic bit array_step(logic [7:0] c);
        int t;
        logic [3:0] k;
        t = pk_level - 1;
        k = pk_kind[t];
        if ((k == FK_ARR_FIRST || k == FK_ARR_SEP) && c == CH_RBRACK)
        begin
            pk_level--;
            add_event(EV_ARR_END, 8'd0, ER_NONE);
            return 1;
        end
        if (k == FK_ARR_SEP)
        begin
            if (c == CH_COMMA)
            begin
                pk_kind[t] = FK_ARR_VAL;
                if (pk_count[t] != IDX_MAX) pk_count[t]++;
                return 1;
            end
            pk_err = ER_ARR_SEP;
            return 0;
        end
        pk_kind[t] = FK_ARR_SEP;
        if (!push_frame(FK_VALUE)) return 0;
        if (value_step(c)) return 1;
        pk_err = (k == FK_ARR_FIRST) ? ER_ARR_VEND : ER_ARR_VALUE;
        return 0;
    endfunction

    function automatic bit object_step(logic [7:0] c);
        int t;
        logic [3:0] k;
        bit ok;
        t = pk_level - 1;
        k = pk_kind[t];
        if ((k == FK_OBJ_KEY || k == FK_OBJ_SEP) && c == CH_RBRACE)
        begin
            pk_level--;
            add_event(EV_OBJ_END, 8'd0, ER_NONE);
            return 1;
        end
        if (k == FK_OBJ_KEY)
        begin
            pk_kind[t] = FK_OBJ_COLON;
            if (!push_frame(FK_KEY_START)) return 0;
            ok = text_step(c);
            if (!ok && pk_err == ER_STR_START) pk_err = ER_KEY_END;
            return ok;
        end
        if (k == FK_OBJ_COLON)
        begin
            if (c == CH_COLON)
            begin
                pk_kind[t] = FK_OBJ_VAL;
                return 1;
            end
            pk_err = ER_COLON;
            return 0;
        end
        if (k == FK_OBJ_VAL)
        begin
            pk_kind[t] = FK_OBJ_SEP;
            if (!push_frame(FK_VALUE)) return 0;
            if (value_step(c)) return 1;
            pk_err = ER_OBJ_VALUE;
            return 0;
        end
        if (c == CH_COMMA)
        begin
            pk_kind[t] = FK_OBJ_COLON;
            return push_frame(FK_KEY_START);
        end
        pk_err = ER_OBJ_SEP;
        return 0;
    endfunction

    function automatic void clear_stack();
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            pk_kind[i] = FK_VALUE;
            pk_count[i] = '0;
        end
        pk_level = 1;
    endfunction

    // work out the events one byte causes and queue them
    function automatic void predict_byte(logic [7:0] c);
        bit consumed;
        logic [3:0] k;
        parse_event_t e;
        consumed = 0;
        step_events.delete();
        if (c == 8'd0) return;
        // an empty stack left by an invalid root byte starts over as one value frame
        if (pk_level == 0) clear_stack();
        if (pk_err != ER_NONE)
            add_event(EV_ERROR, 8'd0, pk_err);
        else
        begin
            k = pk_kind[pk_level-1];
            if (space_char(c) && k != FK_KEY_BODY && k != FK_STR_BODY) return;
            while (!consumed && pk_err == ER_NONE && pk_level > 0)
            begin
                k = pk_kind[pk_level-1];
                if (k == FK_VALUE)
                begin
                    consumed = value_step(c);
                    if (!consumed) pk_err = ER_INVALID;
                end
                else if (k <= FK_OBJ_SEP) consumed = object_step(c);
                else if (k <= FK_ARR_SEP) consumed = array_step(c);
                else if (k <= FK_STR_ESC) consumed = text_step(c);
                else if (k == FK_RAW)
                begin
                    if (token_char(c))
                    begin
                        add_event(EV_RAW_CHAR, c, ER_NONE);
                        consumed = 1;
                    end
                    else
                    begin
                        pk_level--;
                        add_event(EV_RAW_END, 8'd0, ER_NONE);
                    end
                end
                else pk_err = ER_INTERNAL;
            end
            if (pk_err != ER_NONE) add_event(EV_ERROR, 8'd0, pk_err);
            else if (pk_level == 0)
            begin
                add_event(EV_DONE, 8'd0, ER_NONE);
                clear_stack();
            end
        end
        for (int i = 0; i < step_events.size(); i++)
        begin
            e = step_events[i];
            e.last = (i == step_events.size() - 1);
            expected_events.push_back(e);
        end
    endfunction

    // sender: bursts and gaps, holds a stalled item, sends nothing while paused
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            char_in <= 8'd0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else
        begin
            if (char_valid && !char_stall)
                predict_byte(char_in);
            if (char_valid && char_stall)
            begin
                // hold the stalled item
            end
            else if (gap_left > 0)
            begin
                char_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_bytes.size() > 0 && !sender_pause)
            begin
                char_valid <= 1'b1;
                char_in <= pending_bytes.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                char_valid <= 1'b0;
        end
    end

    // receiver: own stall pattern plus a requested long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            event_stall <= 1'b0;
            hold_off <= 0;
            stall_phase <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            if (hold_req && hold_off == 0)
            begin
                hold_off <= 300;
                event_stall <= 1'b1;
            end
            else if (hold_off > 1)
            begin
                hold_off <= hold_off - 1;
                event_stall <= 1'b1;
            end
            else
            begin
                if (hold_off == 1) hold_off <= 0;
                if (stall_phase[9:8] == 2'd0) event_stall <= 1'b0;
                else event_stall <= ($urandom_range(0, 3) == 0);
            end
        end
    end

    // monitor: compare every accepted event with the oldest expectation
    always @(posedge clk)
    begin
        parse_event_t x;
        if (rst_n && event_valid && !event_stall)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event kind %0d", $realtime, event_kind);
                fail_count++;
            end
            else
            begin
                x = expected_events.pop_front();
                if (event_kind !== x.kind || data_byte !== x.data ||
                    error_code !== x.code || nesting_depth !== x.depth ||
                    element_index !== x.index || last !== x.last)
                begin
                    $display("%0t: mismatch expected k%0d d%h e%0d n%0d i%0d l%0d",
                             $realtime, x.kind, x.data, x.code, x.depth, x.index, x.last);
                    $display("%0t:          actual   k%0d d%h e%0d n%0d i%0d l%0d",
                             $realtime, event_kind, data_byte, error_code, nesting_depth,
                             element_index, last);
                    fail_count++;
                end
            end
        end
    end

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) pending_bytes.push_back(s[i]);
    endtask

    // token bytes; a leading u would open a string instead
    function automatic logic [7:0] pick_token();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range("0", "9"));
            1: return 8'($urandom_range("a", "t"));
            2: return 8'($urandom_range("A", "Z"));
            default: return ($urandom_range(0, 1)) ? "-" : ".";
        endcase
    endfunction

    function automatic logic [7:0] pick_noise();
        return 8'($urandom_range(0, 255));
    endfunction

    // build a random well-formed value, depth limited
    task automatic queue_value(int lvl);
        int n;
        case ((lvl > 5) ? $urandom_range(2, 3) : $urandom_range(0, 3))
            0:
            begin
                queue_text(" [");
                n = $urandom_range(0, 3);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) queue_text(",");
                    queue_value(lvl + 1);
                end
                queue_text("]");
            end
            1:
            begin
                queue_text("{");
                n = $urandom_range(0, 2);
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0) queue_text(",\n");
                    pending_bytes.push_back($urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE);
                    queue_text(i ? "k\\t" : "key");
                    queue_text("\" : ");
                    queue_value(lvl + 1);
                end
                queue_text("}");
            end
            2:
            begin
                if ($urandom_range(0, 3) == 0) queue_text("u");
                pending_bytes.push_back(CH_DQUOTE);
                n = $urandom_range(0, 4);
                for (int i = 0; i < n; i++)
                begin
                    if ($urandom_range(0, 4) == 0) pending_bytes.push_back(CH_BSLASH);
                    // body bytes are drawn from the high half, so never a quote or a backslash
                    pending_bytes.push_back(8'($urandom_range(1, 255)) | 8'h80);
                end
                pending_bytes.push_back(CH_SQUOTE);
            end
            default:
            begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) pending_bytes.push_back(pick_token());
            end
        endcase
    endtask

    // wait until the block has drained, then reset nothing; just idle
    task automatic wait_drained();
        while (pending_bytes.size() > 0 || char_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    initial
    begin
        fail_count = 0;
        hold_req = 0;
        sender_pause = 0;
        pk_err = ER_NONE;
        clear_stack();
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed: nested document with escapes, quotes, counters, zero byte
        queue_text("{'a\\n':[1,x.Z,\"s\\r\\q\"],\"b\":{} }");
        pending_bytes.push_back(8'd0);
        queue_text(" u'\t'[] ");
        wait_drained();
        // random documents, each wrapped in an array so a bare token is closed cleanly;
        // errors are sticky, so the error paths come last
        for (int i = 0; i < 16; i++)
        begin
            queue_text("[");
            queue_value(1);
            queue_text("] ");
        end
        // long hold-off while the sender keeps offering items
        hold_req = 1;
        repeat (2) @(posedge clk);
        hold_req = 0;
        wait_drained();
        // counter run over a moderate array, with a pause of the sender part way
        queue_text("[");
        for (int i = 0; i < 20; i++) queue_text("1,");
        queue_text("2] ");
        repeat (30) @(posedge clk);
        // pause until every expected result has come
        sender_pause = 1;
        while (char_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        sender_pause = 0;
        wait_drained();
        // stack overflow gives too deep, then sticky errors with noise, incl. high bytes
        for (int i = 0; i < MAX_DEPTH + 1; i++) queue_text("[");
        for (int i = 0; i < 60; i++) pending_bytes.push_back(pick_noise());
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h80);
        wait_drained();
        if (fail_count == 0)
            $display("json_stream_event_parser_unit_tb passed");
        else
            $display("json_stream_event_parser_unit_tb failed");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("json_stream_event_parser_unit_tb failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/jsep_pkg.sv
hw/rtl/jsep_ctrl.sv
hw/rtl/jsep_dp.sv
hw/rtl/json_stream_event_parser_unit.sv
tb/sv/json_stream_event_parser_unit_tb.sv
